[src/bcd_pkg.sv]
// Package for the BC1/BC3 block decoder: palette types, format codes,
// and endpoint widening and constant-divide helpers. No dependencies.
package bcd_pkg;

	localparam logic       FMT_BC1         = 1'b0;
	localparam logic       FMT_BC3         = 1'b1;
	localparam logic [1:0] REG_FORMAT_MODE = 2'd0;
	localparam logic [1:0] ROW_LAST        = 2'd3;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} rgba_t;

	typedef rgba_t [3:0]      color_pal_t;
	typedef logic [7:0][7:0]  alpha_pal_t;

	typedef struct packed {
		color_pal_t  cpal;
		alpha_pal_t  apal;
		logic [31:0] cidx;
		logic [47:0] aidx;
		logic        bc3;
	} blk_pal_t;

	// x*255/31 = 8x + floor(7x/31)
	function automatic logic [7:0] widen5(input logic [4:0] x);
		logic [15:0] t;
		t = 16'(x) * 16'd1855;
		return 8'({x, 3'b000}) + 8'(t >> 13);
	endfunction

	// x*255/63 = 4x + floor(x/21)
	function automatic logic [7:0] widen6(input logic [5:0] x);
		logic [11:0] t;
		t = 12'(x) * 12'd49;
		return 8'({x, 2'b00}) + 8'(t >> 10);
	endfunction

	function automatic logic [7:0] div3(input logic [9:0] v);
		logic [19:0] p;
		p = 20'(v) * 20'd683;
		return 8'(p >> 11);
	endfunction

	function automatic logic [7:0] div5(input logic [10:0] v);
		logic [20:0] p;
		p = 21'(v) * 21'd1639;
		return 8'(p >> 13);
	endfunction

	function automatic logic [7:0] div7(input logic [10:0] v);
		logic [21:0] p;
		p = 22'(v) * 22'd2341;
		return 8'(p >> 14);
	endfunction

endpackage

[src/bcd_blk_if.sv]
// Input channel of the BC1/BC3 block decoder: one compressed block per word.
// No dependencies.
interface bcd_blk_if;
	logic        valid;
	logic        ready;
	logic [63:0] color_block;
	logic [63:0] alpha_block;

	modport source(output valid, color_block, alpha_block, input ready);
	modport sink(input valid, color_block, alpha_block, output ready);
endinterface

[src/bcd_row_if.sv]
// Output channel of the BC1/BC3 block decoder: one texel row per word.
// No dependencies.
interface bcd_row_if;
	logic        valid;
	logic        ready;
	logic [1:0]  row_index;
	logic [31:0] texel_col0;
	logic [31:0] texel_col1;
	logic [31:0] texel_col2;
	logic [31:0] texel_col3;
	logic        last_row;

	modport source(output valid, row_index, texel_col0, texel_col1, texel_col2, texel_col3,
		last_row, input ready);
	modport sink(input valid, row_index, texel_col0, texel_col1, texel_col2, texel_col3,
		last_row, output ready);
endinterface

[src/bc1_bc3_block_decoder_core.sv]
// Top level of the BC1/BC3 texture block decoder.
// Depends on bcd_pkg, bcd_blk_if, bcd_row_if and bcd_palette.
//
// blk_in takes one compressed 4x4 block per word (color_block, alpha_block,
// byte 0 in the low bits). row_out returns four words per block, rows 0 to 3
// in order, each with four RGBA8 texels (R in bits 7:0, A in 31:24); last_row
// marks row 3. The APB port holds format_mode at byte address 0:
// 0 decodes BC1, 1 takes alpha from the BC3 alpha block. Write it only while
// no block is in flight.
// Row 0 of a block passes the input register, the palette register and the row
// output register; the other rows follow one per cycle while row_out is ready,
// as the single row output register drains the palette register one row per
// cycle. The input register takes the next block while the current one is still
// being emitted.
// Reset clears all valid flags and sets format_mode to BC1. When row_out
// stalls, the current row holds, the palette register holds, and blk_in.ready
// drops once the input register is also full. No data is lost.
module bc1_bc3_block_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	bcd_blk_if.sink     blk_in,
	bcd_row_if.source   row_out
);
	import bcd_pkg::*;

	logic        format_mode_q;

	logic        v_s1;
	logic [63:0] color_s1;
	logic [63:0] alpha_s1;

	logic        v_s2;
	blk_pal_t    pal_s2;
	blk_pal_t    pal_next;
	logic [1:0]  row_q;

	logic        out_v_q;
	logic [1:0]  row_index_q;
	logic [3:0][31:0] texel_q;
	logic        last_row_q;

	logic        out_free;
	logic        emit;
	logic        s2_take;
	logic        s1_move;
	logic        in_fire;
	logic        cfg_wr;
	logic [3:0][31:0] row_texels;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_FORMAT_MODE) ? {31'd0, format_mode_q} : 32'd0;
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_FORMAT_MODE);

	assign out_free     = !out_v_q || row_out.ready;
	assign emit         = v_s2 && out_free;
	assign s2_take      = !v_s2 || (emit && (row_q == ROW_LAST));
	assign s1_move      = v_s1 && s2_take;
	assign blk_in.ready = !v_s1 || s2_take;
	assign in_fire      = blk_in.valid && blk_in.ready;

	bcd_palette u_palette (
		.color_block (color_s1),
		.alpha_block (alpha_s1),
		.bc3         (format_mode_q == FMT_BC3),
		.pal         (pal_next)
	);

	always_comb begin
		logic [3:0]  t;
		logic [1:0]  ci;
		logic [2:0]  ai;
		rgba_t       px;

		for (int c = 0; c < 4; c++) begin
			t  = {row_q, 2'(c)};
			ci = pal_s2.cidx[{t, 1'b0} +: 2];
			ai = pal_s2.aidx[6'(t) * 6'd3 +: 3];
			px = pal_s2.cpal[ci];
			if (pal_s2.bc3) begin
				px.a = pal_s2.apal[ai];
			end
			row_texels[c] = px;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= FMT_BC1;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			row_q         <= '0;
			out_v_q       <= 1'b0;
		end else begin
			if (cfg_wr) begin
				format_mode_q <= pwdata[0];
			end
			if (in_fire) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move) begin
				v_s2  <= 1'b1;
				row_q <= '0;
			end else if (emit) begin
				row_q <= row_q + 2'd1;
				if (row_q == ROW_LAST) begin
					v_s2 <= 1'b0;
				end
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (row_out.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			color_s1 <= blk_in.color_block;
			alpha_s1 <= blk_in.alpha_block;
		end
		if (s1_move) begin
			pal_s2 <= pal_next;
		end
		if (emit) begin
			row_index_q <= row_q;
			texel_q     <= row_texels;
			last_row_q  <= (row_q == ROW_LAST);
		end
	end

	assign row_out.valid      = out_v_q;
	assign row_out.row_index  = row_index_q;
	assign row_out.texel_col0 = texel_q[0];
	assign row_out.texel_col1 = texel_q[1];
	assign row_out.texel_col2 = texel_q[2];
	assign row_out.texel_col3 = texel_q[3];
	assign row_out.last_row   = last_row_q;

endmodule

[src/bcd_palette.sv]
// Color and alpha palette builder for one BC1/BC3 block, combinational.
// Depends on bcd_pkg.
module bcd_palette (
	input  logic              [63:0] color_block,
	input  logic              [63:0] alpha_block,
	input  logic                     bc3,
	output bcd_pkg::blk_pal_t        pal
);
	import bcd_pkg::*;

	always_comb begin
		logic [15:0]     c0, c1;
		logic [7:0]      a0, a1;
		logic [2:0][7:0] e0, e1, p2, p3, mid;

		c0 = color_block[15:0];
		c1 = color_block[31:16];
		a0 = alpha_block[7:0];
		a1 = alpha_block[15:8];

		e0[0] = widen5(c0[15:11]);
		e0[1] = widen6(c0[10:5]);
		e0[2] = widen5(c0[4:0]);
		e1[0] = widen5(c1[15:11]);
		e1[1] = widen6(c1[10:5]);
		e1[2] = widen5(c1[4:0]);

		for (int k = 0; k < 3; k++) begin
			p2[k]  = div3(10'({e0[k], 1'b0}) + 10'(e1[k]) + 10'd1);
			p3[k]  = div3(10'(e0[k]) + 10'({e1[k], 1'b0}) + 10'd1);
			mid[k] = 8'((9'(e0[k]) + 9'(e1[k])) >> 1);
		end

		pal.cpal[0] = '{a: 8'hFF, b: e0[2], g: e0[1], r: e0[0]};
		pal.cpal[1] = '{a: 8'hFF, b: e1[2], g: e1[1], r: e1[0]};
		if (c0 > c1) begin
			pal.cpal[2] = '{a: 8'hFF, b: p2[2], g: p2[1], r: p2[0]};
			pal.cpal[3] = '{a: 8'hFF, b: p3[2], g: p3[1], r: p3[0]};
		end else begin
			pal.cpal[2] = '{a: 8'hFF, b: mid[2], g: mid[1], r: mid[0]};
			pal.cpal[3] = '0;
		end

		pal.apal[0] = a0;
		pal.apal[1] = a1;
		if (a0 > a1) begin
			for (int i = 1; i <= 6; i++) begin
				pal.apal[i + 1] = div7(11'(a0) * 11'(7 - i) + 11'(a1) * 11'(i) + 11'd3);
			end
		end else begin
			for (int i = 1; i <= 4; i++) begin
				pal.apal[i + 1] = div5(11'(a0) * 11'(5 - i) + 11'(a1) * 11'(i) + 11'd2);
			end
			pal.apal[6] = 8'h00;
			pal.apal[7] = 8'hFF;
		end

		pal.cidx = color_block[63:32];
		pal.aidx = alpha_block[63:16];
		pal.bc3  = bc3;
	end

endmodule

[bench/bc1_bc3_block_decoder_core_tb.sv]
// Testbench for bc1_bc3_block_decoder_core: directed and random compressed blocks in BC1
// and BC3 mode, each texel row checked against an in-bench decoder with random stalls.
// Depends on bcd_pkg, bcd_blk_if, bcd_row_if and the decoder RTL.
module bc1_bc3_block_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bcd_pkg::*;

	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [1:0]       row_index;
		rgba_t [3:0]      texel;
		logic             last_row;
	} row_word_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bcd_blk_if blk();
	bcd_row_if rows();

	row_word_t pending_rows[$];
	logic      fmt_mode;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        err_count;
	int        stall_cycles;

	bc1_bc3_block_decoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.blk_in(blk),
		.row_out(rows)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch on %s: got %h, expected %h", field, got, want);
		err_count++;
	endtask

	task automatic decode_block(input logic [63:0] cb, input logic [63:0] ab);
		int          cpal [4][4];
		int          apal [8];
		logic [15:0] c0;
		logic [15:0] c1;
		logic [15:0] ep;
		int          a0;
		int          a1;
		int          t;
		int          ci;
		row_word_t   w;
		rgba_t       px;
		c0 = cb[15:0];
		c1 = cb[31:16];
		a0 = int'(ab[7:0]);
		a1 = int'(ab[15:8]);
		for (int e = 0; e < 2; e++) begin
			ep = (e == 0) ? c0 : c1;
			cpal[e][0] = int'(ep[15:11]) * 255 / 31;
			cpal[e][1] = int'(ep[10:5]) * 255 / 63;
			cpal[e][2] = int'(ep[4:0]) * 255 / 31;
			cpal[e][3] = 255;
		end
		for (int k = 0; k < 3; k++) begin
			if (c0 > c1) begin
				cpal[2][k] = (2 * cpal[0][k] + cpal[1][k] + 1) / 3;
				cpal[3][k] = (cpal[0][k] + 2 * cpal[1][k] + 1) / 3;
			end else begin
				cpal[2][k] = (cpal[0][k] + cpal[1][k]) / 2;
				cpal[3][k] = 0;
			end
		end
		cpal[2][3] = 255;
		cpal[3][3] = (c0 > c1) ? 255 : 0;
		apal[0] = a0;
		apal[1] = a1;
		if (a0 > a1) begin
			for (int i = 1; i <= 6; i++)
				apal[i + 1] = ((7 - i) * a0 + i * a1 + 3) / 7;
		end else begin
			for (int i = 1; i <= 4; i++)
				apal[i + 1] = ((5 - i) * a0 + i * a1 + 2) / 5;
			apal[6] = 0;
			apal[7] = 255;
		end
		for (int r = 0; r < 4; r++) begin
			w.row_index = 2'(r);
			w.last_row = (2'(r) == ROW_LAST);
			for (int c = 0; c < 4; c++) begin
				t = 4 * r + c;
				ci = int'(cb[32 + 2 * t +: 2]);
				px.r = 8'(cpal[ci][0]);
				px.g = 8'(cpal[ci][1]);
				px.b = 8'(cpal[ci][2]);
				px.a = (fmt_mode == FMT_BC3) ? 8'(apal[int'(ab[16 + 3 * t +: 3])])
					: 8'(cpal[ci][3]);
				w.texel[c] = px;
			end
			pending_rows = {pending_rows, w};
		end
	endtask

	task automatic send_block(input logic [63:0] cb, input logic [63:0] ab);
		while ($urandom_range(99) < send_idle_pct) begin
			blk.valid <= 1'b0;
			@(posedge clk);
		end
		blk.valid <= 1'b1;
		blk.color_block <= cb;
		blk.alpha_block <= ab;
		@(posedge clk);
		while (!blk.ready)
			@(posedge clk);
		decode_block(cb, ab);
	endtask

	task automatic hold_until_drained();
		blk.valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_format(input logic mode);
		logic [31:0] word;
		hold_until_drained();
		repeat (4) @(posedge clk);
		word = $urandom;
		word[0] = mode;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 2'(4 * REG_FORMAT_MODE);
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		fmt_mode = word[0];
	endtask

	task automatic random_block(output logic [63:0] cb, output logic [63:0] ab);
		logic [15:0] c0;
		logic [15:0] c1;
		logic [15:0] tmp;
		logic [7:0]  a0;
		logic [7:0]  a1;
		logic [7:0]  tmp8;
		cb = {$urandom, $urandom};
		ab = {$urandom, $urandom};
		c0 = cb[15:0];
		c1 = cb[31:16];
		a0 = ab[7:0];
		a1 = ab[15:8];
		case ($urandom_range(7))
			0: c1 = c0;
			1: c0 = 16'hFFFF;
			2: c1 = 16'h0000;
			3: a1 = a0;
			4: a0 = 8'hFF;
			5: a1 = 8'h00;
			default: ;
		endcase
		if (($urandom_range(1) == 1) == (c0 < c1)) begin
			tmp = c0;
			c0 = c1;
			c1 = tmp;
		end
		if (($urandom_range(1) == 1) == (a0 < a1)) begin
			tmp8 = a0;
			a0 = a1;
			a1 = tmp8;
		end
		cb[31:0] = {c1, c0};
		ab[15:0] = {a1, a0};
	endtask

	task automatic test_bc1_directed();
		send_block(64'h0, 64'h0);
		send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, {$urandom, $urandom});
		send_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, {$urandom, $urandom});
		send_block({32'h1B1B_1B1B, 16'h07E0, 16'hF800}, {$urandom, $urandom});
		send_block({$urandom, 16'hF800, 16'h001F}, {$urandom, $urandom});
		send_block({32'hE4E4_E4E4, 16'h8410, 16'h8411}, {$urandom, $urandom});
	endtask

	task automatic test_bc3_directed();
		write_format(FMT_BC3);
		send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, {{2{24'o76543210}}, 8'h00, 8'hFF});
		send_block({32'h1B1B_1B1B, 16'h001F, 16'hF81F}, {{2{24'o76543210}}, 8'hFF, 8'h00});
		send_block({$urandom, $urandom}, {{2{24'o76543210}}, 8'h80, 8'h80});
		send_block({$urandom, $urandom}, {48'hFFFF_FFFF_FFFF, 8'h00, 8'h00});
		send_block({$urandom, $urandom}, {{2{24'o66666666}}, 8'hFF, 8'hFF});
		send_block({32'hE4E4_E4E4, 16'h1234, 16'h1235}, {{2{24'o76543210}}, 8'h40, 8'h41});
		send_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, {{2{24'o01234567}}, 8'h10, 8'hF0});
		send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_block(64'h0, 64'h0);
		write_format(FMT_BC1);
		send_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, {{2{24'o76543210}}, 8'h10, 8'hF0});
	endtask

	task automatic test_random();
		logic [63:0] cb;
		logic [63:0] ab;
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 29;
					recv_idle_pct = 56;
				end
				1: begin
					send_idle_pct = 56;
					recv_idle_pct = 29;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 2; seg++) begin
				write_format(((p + seg) % 2 == 1) ? FMT_BC3 : FMT_BC1);
				for (int n = 0; n < 33; n++) begin
					if (n == 16)
						hold_until_drained();
					random_block(cb, ab);
					send_block(cb, ab);
				end
			end
		end
	endtask

	always @(posedge clk) begin : check_rows
		row_word_t         want;
		logic [3:0][31:0]  got_tex;
		if (arst_n && rows.valid && rows.ready) begin
			if (pending_rows.size() == 0) begin
				report_mismatch("unexpected row", 32'(rows.row_index), 32'h0);
			end else begin
				want = pending_rows.pop_front();
				got_tex = {rows.texel_col3, rows.texel_col2, rows.texel_col1, rows.texel_col0};
				if (rows.row_index !== want.row_index)
					report_mismatch("row_index", 32'(rows.row_index), 32'(want.row_index));
				for (int c = 0; c < 4; c++)
					if (got_tex[c] !== want.texel[c])
						report_mismatch($sformatf("texel_col%0d row %0d", c, want.row_index),
							got_tex[c], want.texel[c]);
				if (rows.last_row !== want.last_row)
					report_mismatch("last_row", 32'(rows.last_row), 32'(want.last_row));
			end
		end
		rows.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((blk.valid && blk.ready) || (rows.valid && rows.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		blk.valid = 1'b0;
		blk.color_block = '0;
		blk.alpha_block = '0;
		rows.ready = 1'b0;
		fmt_mode = FMT_BC1;
		send_idle_pct = 29;
		recv_idle_pct = 56;
		err_count = 0;
		stall_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bc1_directed();
		test_bc3_directed();
		test_random();
		hold_until_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
